// ===== hw/rtl/haq_pkg.sv =====
package haq_pkg;

  localparam int unsigned ROBOT_COUNT = 8;
  localparam int unsigned ID_W        = 3;
  localparam int unsigned CYCLE_W     = 32;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned TOL_W       = 15;
  localparam int unsigned GAP_W       = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned IN_DATA_W   = 88;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam logic [GAP_W-1:0] STALE_GAP_RST    = 8'd10;
  localparam logic [CNT_W-1:0] STABLE_COUNT_RST = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_GAP    = 1'b0,
    REG_STABLE_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                      ball_ok;
    logic [ID_W-1:0]           robot_id;
    logic signed [ANGLE_W-1:0] robot_heading;
    logic [TOL_W-1:0]          tolerance;
    logic signed [ANGLE_W-1:0] target_heading;
    logic [CYCLE_W-1:0]        frame_cycle;
  } item_t;

endpackage

// ===== hw/rtl/heading_alignment_qualifier.sv =====
// Path: an input transfer loads the input register; the item's result is then
// loaded into the result register, from which it is valid on m_axis.
// Throughput: one item per cycle while m_axis is not stalled; the per-robot
// count and last-cycle update is a read-modify-write on flop arrays, so
// back-to-back items for the same robot see each other's state without stalls.
// Reset (rst_ni low, async): clears all robot state, restores registers.
module heading_alignment_qualifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side, tdata from bit 0: frame_cycle, target_heading, tolerance,
  // robot_heading, robot_id, ball_ok, zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [haq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // Master side, tdata from bit 0: aligned, zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [haq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [haq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [haq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import haq_pkg::*;

  // Configuration registers
  logic [GAP_W-1:0] stale_gap_q;
  logic [CNT_W-1:0] stable_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_gap_q    <= STALE_GAP_RST;
      stable_count_q <= STABLE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STALE_GAP:    stale_gap_q    <= cfg_data_i[GAP_W-1:0];
        REG_STABLE_COUNT: stable_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic  in_valid_q;
  item_t in_q;
  logic  advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Unpack the bus fields, lowest first
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.frame_cycle    <= s_axis_tdata[31:0];
      in_q.target_heading <= s_axis_tdata[47:32];
      in_q.tolerance      <= s_axis_tdata[62:48];
      in_q.robot_heading  <= s_axis_tdata[78:63];
      in_q.robot_id       <= s_axis_tdata[81:79];
      in_q.ball_ok        <= s_axis_tdata[82];
    end
  end

  // Per-robot state
  logic [ROBOT_COUNT-1:0][CNT_W-1:0]   stab_q;
  logic [ROBOT_COUNT-1:0][CYCLE_W-1:0] last_q;

  logic                       id_ok;
  logic                       evaluate;
  logic [CYCLE_W-1:0]         gap;
  logic                       stale;
  logic [ANGLE_W-1:0]         tol_ext;
  logic [ANGLE_W-1:0]         lo;
  logic [ANGLE_W-1:0]         hi;
  logic signed [ANGLE_W-1:0]  m1;
  logic signed [ANGLE_W-1:0]  m2;
  logic signed [ANGLE_W-1:0]  margin;
  logic [ANGLE_W-1:0]         two_tol;
  logic                       in_window;
  logic [CNT_W-1:0]           cnt_old;
  logic [CNT_W-1:0]           cnt_d;
  logic                       aligned_d;

  always_comb begin
    id_ok    = ({1'b0, in_q.robot_id} < (ID_W+1)'(ROBOT_COUNT));
    evaluate = in_q.ball_ok && id_ok;

    // A gap that reads negative never marks the robot stale
    gap   = in_q.frame_cycle - last_q[in_q.robot_id];
    stale = !gap[CYCLE_W-1] && (gap > CYCLE_W'(stale_gap_q));

    // Window edges wrap naturally as binary angles
    tol_ext = {1'b0, in_q.tolerance};
    lo      = in_q.target_heading - tol_ext;
    hi      = in_q.target_heading + tol_ext;
    m1      = in_q.robot_heading - lo;
    m2      = hi - in_q.robot_heading;
    margin  = (m1 > m2) ? m1 : m2;
    two_tol = {in_q.tolerance, 1'b0};
    // Positive margin makes the unsigned compare exact
    in_window = (margin > 0) && ($unsigned(margin) < two_tol);

    cnt_old   = stale ? '0 : stab_q[in_q.robot_id];
    aligned_d = 1'b0;
    if (in_window) begin
      if (cnt_old >= stable_count_q) begin
        aligned_d = 1'b1;
        cnt_d     = stable_count_q;
      end else begin
        cnt_d = cnt_old + CNT_W'(1);
      end
    end else begin
      cnt_d = (cnt_old != '0) ? cnt_old - CNT_W'(1) : '0;
    end
    aligned_d = aligned_d && evaluate;
  end

  // Write back the count and the cycle of this update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stab_q <= '0;
      last_q <= '0;
    end else if (advance && evaluate) begin
      stab_q[in_q.robot_id] <= cnt_d;
      last_q[in_q.robot_id] <= in_q.frame_cycle;
    end
  end

  // Result register: hold while the sink stalls
  logic out_valid_q;
  logic aligned_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      aligned_q <= aligned_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W-1)'(0), aligned_q};

  // Checks
  a_aligned_sets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && aligned_d |=> stab_q[$past(in_q.robot_id)] == $past(stable_count_q))
    else $error("aligned result without count at stable_count");

  a_skip_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.ball_ok |=> $stable(stab_q) && $stable(last_q))
    else $error("skipped item changed robot state");

  a_cycle_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && evaluate |=> last_q[$past(in_q.robot_id)] == $past(in_q.frame_cycle))
    else $error("last update cycle not recorded");

  a_skip_not_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.ball_ok |=> !aligned_q)
    else $error("aligned reported for skipped item");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with empty input register");

endmodule

// ===== verif/heading_alignment_qualifier_tb.sv =====
module heading_alignment_qualifier_tb;
  import haq_pkg::*;

  // Stop the run after this many cycles in a row with no transfer on either side.
  localparam int unsigned STALL_LIMIT = 4000;
  // Cycles to wait after the last expected result has been seen, when settling.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PAD_W = IN_DATA_W - $bits(item_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0: frame_cycle, target_heading, tolerance, robot_heading,
  // robot_id, ball_ok, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0: aligned, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  heading_alignment_qualifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the block: per-robot stability count and last update cycle,
  // plus the two configuration registers.
  logic [CNT_W-1:0]   shadow_count [ROBOT_COUNT];
  logic [CYCLE_W-1:0] shadow_last_cycle [ROBOT_COUNT];
  logic [GAP_W-1:0]   shadow_stale_gap;
  logic [CNT_W-1:0]   shadow_stable_count;

  // Expected aligned flags, oldest first.
  logic aligned_q [$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  // Random stimulus state: a running frame counter and a robot that gets
  // most of the traffic so its count can build up.
  logic [CYCLE_W-1:0] frame_now = '0;
  logic [ID_W-1:0]    focus_robot = '0;

  logic exp_aligned;

  // Apply one accepted item to the shadow state and return the aligned flag.
  function automatic logic advance_alignment(item_t it);
    logic [CYCLE_W-1:0]        gap;
    logic [ANGLE_W-1:0]        lo, hi;
    logic signed [ANGLE_W-1:0] d_lo, d_hi;
    int                        margin, window;
    logic [CNT_W-1:0]          cnt;
    logic                      aligned;
    aligned = 1'b0;
    if (!it.ball_ok) return 1'b0;

    // A gap that reads negative as signed (backward or huge) never clears.
    gap = it.frame_cycle - shadow_last_cycle[it.robot_id];
    if (!gap[CYCLE_W-1] && gap > CYCLE_W'(shadow_stale_gap)) shadow_count[it.robot_id] = '0;
    shadow_last_cycle[it.robot_id] = it.frame_cycle;

    // Binary angles: 16-bit wraparound does the +/- pi folding.
    lo   = it.target_heading - it.tolerance;
    hi   = it.target_heading + it.tolerance;
    d_lo = it.robot_heading - lo;
    d_hi = hi - it.robot_heading;
    margin = (d_lo > d_hi) ? int'(d_lo) : int'(d_hi);
    window = 2 * int'(it.tolerance);

    cnt = shadow_count[it.robot_id];
    if (margin > 0 && margin < window) begin
      if (cnt >= shadow_stable_count) begin
        aligned = 1'b1;
        cnt = shadow_stable_count;
      end else begin
        cnt = cnt + 1'b1;
      end
    end else if (cnt != '0) begin
      cnt = cnt - 1'b1;
    end
    shadow_count[it.robot_id] = cnt;
    return aligned;
  endfunction

  function automatic item_t mk_item(logic [CYCLE_W-1:0] cyc, int tgt, int tol, int hdg,
                                    int id, bit ok);
    item_t it;
    it.frame_cycle    = cyc;
    it.target_heading = ANGLE_W'(tgt);
    it.tolerance      = TOL_W'(tol);
    it.robot_heading  = ANGLE_W'(hdg);
    it.robot_id       = ID_W'(id);
    it.ball_ok        = ok;
    return it;
  endfunction

  function automatic item_t next_random_item();
    item_t           it;
    logic [95:0]     raw;
    int unsigned     kind;
    int              off;
    kind = $urandom_range(99);
    if ($urandom_range(9) == 0) focus_robot = ID_W'($urandom_range(ROBOT_COUNT - 1));
    frame_now = frame_now + CYCLE_W'($urandom_range(3));
    // Occasionally jump the frame counter anywhere, forward or backward.
    if (kind < 4) frame_now = frame_now + CYCLE_W'($urandom);

    if (kind >= 90) begin
      // Noise: every field fully random.
      raw = {$urandom, $urandom, $urandom};
      it  = raw[$bits(item_t)-1:0];
      return it;
    end

    it.frame_cycle    = frame_now;
    it.robot_id       = ($urandom_range(99) < 65) ? focus_robot
                                                  : ID_W'($urandom_range(ROBOT_COUNT - 1));
    it.target_heading = ANGLE_W'($urandom);
    case ($urandom_range(9))
      0:       it.tolerance = '0;
      1:       it.tolerance = TOL_W'(32767 - $urandom_range(15));
      2, 3:    it.tolerance = TOL_W'($urandom);
      default: it.tolerance = TOL_W'($urandom_range(1, 2000));
    endcase
    it.ball_ok = ($urandom_range(99) < 90);

    if (kind < 75) begin
      // Mostly inside the window, with a little spill over either edge.
      off = int'($urandom_range(0, 2 * int'(it.tolerance) + 4)) - int'(it.tolerance) - 2;
      it.robot_heading = it.target_heading + ANGLE_W'(off);
    end else if (kind < 82) begin
      it.robot_heading = $urandom_range(1) ? it.target_heading + it.tolerance
                                           : it.target_heading - it.tolerance;
    end else begin
      it.robot_heading = ANGLE_W'($urandom);
    end
    return it;
  endfunction

  // Present one item, holding it until the block takes it.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, it};
    do @(posedge clk_i); while (!s_axis_tready);
    aligned_q.push_back(advance_alignment(it));
  endtask

  // Drop valid and hold off until every expected result has been seen.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (aligned_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_STALE_GAP:    shadow_stale_gap    = value[GAP_W-1:0];
      REG_STABLE_COUNT: shadow_stable_count = value[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Count up to stable_count, report, then step onto both window edges.
  task automatic test_window_edges();
    repeat (3) send_item(mk_item(1, 0, 100, 0, 0, 1));
    send_item(mk_item(4, 0, 100, 100, 0, 1));
    send_item(mk_item(5, 0, 100, -100, 0, 1));
  endtask

  // Empty window, including a heading exactly pi away from the target.
  task automatic test_zero_tolerance();
    send_item(mk_item(1, 1234, 0, 1234, 4, 1));
    send_item(mk_item(2, 0, 0, -32768, 4, 1));
  endtask

  task automatic test_angle_extremes();
    send_item(mk_item(1, -32768, 32767, 32767, 5, 1));
    send_item(mk_item(2, 32767, 32767, -32768, 5, 1));
    send_item(mk_item(3, 32767, 1, 32767, 6, 1));
  endtask

  // Ball lost: result 0 and robot state untouched.
  task automatic test_ball_not_ok();
    send_item(mk_item(6, 0, 100, 0, 0, 0));
    send_item(mk_item(32'hFFFF_FFFF, -1, 32767, -1, 7, 0));
  endtask

  // Gap equal to stale_gap keeps the count, one more clears it; backward and
  // huge gaps (negative as signed) never clear.
  task automatic test_stale_gap();
    send_item(mk_item(100, 0, 50, 0, 1, 1));
    send_item(mk_item(110, 0, 50, 0, 1, 1));
    send_item(mk_item(121, 0, 50, 0, 1, 1));
    send_item(mk_item(1000, 0, 50, 0, 2, 1));
    send_item(mk_item(1001, 0, 50, 0, 2, 1));
    send_item(mk_item(500, 0, 50, 0, 2, 1));
    send_item(mk_item(32'h8000_01F4, 0, 50, 0, 2, 1));
  endtask

  // Build a count, then lower stable_count below it.
  task automatic test_lowered_stable_count();
    drain_results();
    write_reg(REG_STABLE_COUNT, 8'd8);
    send_item(mk_item(1, 300, 20, 300, 3, 1));
    send_item(mk_item(2, 300, 20, 305, 3, 1));
    send_item(mk_item(3, 300, 20, 295, 3, 1));
    drain_results();
    write_reg(REG_STABLE_COUNT, 8'd1);
    send_item(mk_item(4, 300, 20, 300, 3, 1));
  endtask

  // Random traffic in four chunks, each under its own register setting.
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_items);
    logic [CFG_DATA_W-1:0] gap_val, cnt_val;
    for (int chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0: begin
          gap_val = 8'd0;
          cnt_val = 8'h0F;
        end
        1: begin
          gap_val = 8'd255;
          cnt_val = 8'h00;
        end
        default: begin
          gap_val = $urandom_range(1) ? CFG_DATA_W'($urandom_range(255))
                                      : CFG_DATA_W'($urandom_range(20));
          // Upper nibble is outside the register and must be dropped.
          cnt_val = CFG_DATA_W'($urandom);
        end
      endcase
      drain_results();
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      write_reg(REG_STALE_GAP, gap_val);
      write_reg(REG_STABLE_COUNT, cnt_val);
      frame_now = CYCLE_W'($urandom);
      repeat (n_items / 4) send_item(next_random_item());
    end
  endtask

  // Sender holds off mid-stream until the result stream is empty.
  task automatic test_drain_pause();
    repeat (20) send_item(next_random_item());
    s_axis_tvalid <= 1'b0;
    while (aligned_q.size() != 0) @(posedge clk_i);
    repeat (20) send_item(next_random_item());
  endtask

  // Receiver: stall at random per the current idle rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (aligned_q.size() == 0) begin
        $error("aligned: expected none, got %0b", m_axis_tdata[0]);
        mismatches++;
      end else begin
        exp_aligned = aligned_q.pop_front();
        if (exp_aligned !== m_axis_tdata[0]) begin
          $error("aligned: expected %0b, got %0b", exp_aligned, m_axis_tdata[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transfer on either side resets the stall count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < ROBOT_COUNT; i++) begin
      shadow_count[i]      = '0;
      shadow_last_cycle[i] = '0;
    end
    shadow_stale_gap    = STALE_GAP_RST;
    shadow_stable_count = STABLE_COUNT_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tests use the reset register values; the last one sets its own.
    snd_idle_pct = 15;
    rcv_idle_pct = 83;
    test_window_edges();
    test_zero_tolerance();
    test_angle_extremes();
    test_ball_not_ok();
    test_stale_gap();
    test_lowered_stable_count();

    test_random_traffic(15, 83, 296);
    test_drain_pause();
    test_random_traffic(83, 15, 296);
    test_random_traffic(0, 0, 296);

    drain_results();
    if (aligned_q.size() != 0) begin
      $error("aligned: %0d results never arrived", aligned_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/haq_pkg.sv
hw/rtl/heading_alignment_qualifier.sv
verif/heading_alignment_qualifier_tb.sv
